// ===== design/cwb_pkg.sv =====
// cwb_pkg: shared types and constants for the collider world bounds pipeline.
// No dependencies; imported by every cwb module and the top level.
package cwb_pkg;

    localparam int COORD_W  = 24;  // Q16.8 signed coordinate
    localparam int EXT_W    = 23;  // Q15.8 unsigned half extent
    localparam int MARGIN_W = 16;
    localparam int MAT_W    = 34;  // matrix entry, signed Q.28
    localparam int RC_W     = 32;  // rotated center after rounding
    localparam int RAD_W    = 30;  // box half-width after rounding
    localparam int Q_FRAC   = 28;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
    localparam logic signed [MAT_W-1:0]   ONE_Q28   = 34'sh010000000;

    // Per-item data that rides along the pipeline next to the math.
    typedef struct packed {
        logic                           shape_kind;  // 0 box, 1 sphere
        logic                           body_live;
        logic [2:0][COORD_W-1:0]        pos;
        logic [2:0][COORD_W-1:0]        ctr;
        logic [2:0][EXT_W-1:0]          ext;
    } t_side;

endpackage

// ===== design/cwb_matrix.sv =====
// cwb_matrix: quaternion to rotation matrix, two register stages.
// Stage 1 forms the nine component products, stage 2 the Q.28 entries.
// Depends on cwb_pkg.
module cwb_matrix
    import cwb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic [63:0]             i_quat,
    input  t_side                   i_side,
    output logic                    o_vld,
    output logic signed [MAT_W-1:0] o_m [9],   // index column*3 + row
    output t_side                   o_side
);

    localparam int XX = 0, YY = 1, ZZ = 2, XY = 3, XZ = 4, YZ = 5, WX = 6, WY = 7, WZ = 8;

    logic signed [15:0] qw, qx, qy, qz;
    logic signed [31:0] n_p [9];
    logic signed [31:0] r_p [9];
    logic               r_vld1;
    t_side              r_side1;

    logic signed [MAT_W-1:0] pe [9];
    logic signed [MAT_W-1:0] n_m [9];
    logic signed [MAT_W-1:0] r_m [9];
    logic                    r_vld2;
    t_side                   r_side2;

    assign qw = $signed(i_quat[63:48]);
    assign qx = $signed(i_quat[47:32]);
    assign qy = $signed(i_quat[31:16]);
    assign qz = $signed(i_quat[15:0]);

    always_comb begin
        n_p[XX] = qx * qx;
        n_p[YY] = qy * qy;
        n_p[ZZ] = qz * qz;
        n_p[XY] = qx * qy;
        n_p[XZ] = qx * qz;
        n_p[YZ] = qy * qz;
        n_p[WX] = qw * qx;
        n_p[WY] = qw * qy;
        n_p[WZ] = qw * qz;
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            pe[k] = MAT_W'(r_p[k]);
        end
        n_m[0] = ONE_Q28 - ((pe[YY] + pe[ZZ]) <<< 1);
        n_m[1] = (pe[XY] + pe[WZ]) <<< 1;
        n_m[2] = (pe[XZ] - pe[WY]) <<< 1;
        n_m[3] = (pe[XY] - pe[WZ]) <<< 1;
        n_m[4] = ONE_Q28 - ((pe[XX] + pe[ZZ]) <<< 1);
        n_m[5] = (pe[YZ] + pe[WX]) <<< 1;
        n_m[6] = (pe[XZ] + pe[WY]) <<< 1;
        n_m[7] = (pe[YZ] - pe[WX]) <<< 1;
        n_m[8] = ONE_Q28 - ((pe[XX] + pe[YY]) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
        r_p     <= n_p;
        r_side1 <= i_side;
        r_m     <= n_m;
        r_side2 <= r_side1;
    end

    assign o_vld  = r_vld2;
    assign o_m    = r_m;
    assign o_side = r_side2;

endmodule

// ===== design/cwb_xform.sv =====
// cwb_xform: rotates the local center and forms box half-widths.
// Stage 3 holds the eighteen products, stage 4 the rounded row sums.
// Depends on cwb_pkg.
module cwb_xform
    import cwb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic signed [MAT_W-1:0] i_m [9],
    input  t_side                   i_side,
    output logic                    o_vld,
    output logic signed [RC_W-1:0]  o_rc [3],
    output logic [RAD_W-1:0]        o_rad [3],
    output t_side                   o_side
);

    localparam int PC_W  = MAT_W + COORD_W;       // signed center product
    localparam int PH_W  = MAT_W - 1 + EXT_W;     // unsigned half-width product
    localparam int ACC_W = PC_W + 2;
    localparam int HA_W  = PH_W + 2;

    logic [MAT_W-2:0]        mabs [9];
    logic signed [PC_W-1:0]  n_pc [9];
    logic [PH_W-1:0]         n_ph [9];
    logic signed [PC_W-1:0]  r_pc [9];
    logic [PH_W-1:0]         r_ph [9];
    logic                    r_vld3;
    t_side                   r_side3;

    logic signed [ACC_W-1:0] acc [3];
    logic [HA_W-1:0]         ha [3];
    logic signed [RC_W-1:0]  n_rc [3];
    logic [RAD_W-1:0]        n_rad [3];
    logic signed [RC_W-1:0]  r_rc [3];
    logic [RAD_W-1:0]        r_rad [3];
    logic                    r_vld4;
    t_side                   r_side4;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < 3; i++) begin
                mabs[c*3+i] = i_m[c*3+i][MAT_W-1] ? (MAT_W-1)'(-i_m[c*3+i])
                                                   : (MAT_W-1)'(i_m[c*3+i]);
                n_pc[c*3+i] = i_m[c*3+i] * $signed(i_side.ctr[c]);
                n_ph[c*3+i] = mabs[c*3+i] * i_side.ext[c];
            end
        end
    end

    // round half up: add half an LSB, then taking the bits above the fraction keeps floor semantics
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = ACC_W'(r_pc[i]) + ACC_W'(r_pc[3+i]) + ACC_W'(r_pc[6+i])
                   + (ACC_W'(1) <<< (Q_FRAC-1));
            ha[i]  = HA_W'(r_ph[i]) + HA_W'(r_ph[3+i]) + HA_W'(r_ph[6+i])
                   + (HA_W'(1) << (Q_FRAC-1));
            n_rc[i]  = acc[i][Q_FRAC +: RC_W];
            n_rad[i] = ha[i][Q_FRAC +: RAD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            r_vld3 <= i_vld;
            r_vld4 <= r_vld3;
        end
        r_pc    <= n_pc;
        r_ph    <= n_ph;
        r_side3 <= i_side;
        r_rc    <= n_rc;
        r_rad   <= n_rad;
        r_side4 <= r_side3;
    end

    assign o_vld  = r_vld4;
    assign o_rc   = r_rc;
    assign o_rad  = r_rad;
    assign o_side = r_side4;

endmodule

// ===== design/cwb_bound.sv =====
// cwb_bound: final stage, adds position and rotated center, then radius and margin each way, then saturates.
// Dead bodies get the inverted empty box. Depends on cwb_pkg.
module cwb_bound
    import cwb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic signed [RC_W-1:0]    i_rc [3],
    input  logic [RAD_W-1:0]          i_rad [3],
    input  t_side                     i_side,
    input  logic [MARGIN_W-1:0]       i_margin,
    output logic                      o_done,
    output logic                      o_box_valid,
    output logic signed [COORD_W-1:0] o_min [3],
    output logic signed [COORD_W-1:0] o_max [3]
);

    localparam int S_W = RC_W + 2;

    logic signed [S_W-1:0]     p [3];
    logic signed [S_W-1:0]     rad [3];
    logic signed [S_W-1:0]     lo [3];
    logic signed [S_W-1:0]     hi [3];
    logic signed [S_W-1:0]     mg;
    logic signed [COORD_W-1:0] n_min [3];
    logic signed [COORD_W-1:0] n_max [3];
    logic signed [COORD_W-1:0] r_min [3];
    logic signed [COORD_W-1:0] r_max [3];
    logic                      r_done;
    logic                      r_live;

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [S_W-1:0] v);
        if (v > S_W'(COORD_MAX)) begin
            return COORD_MAX;
        end else if (v < S_W'(COORD_MIN)) begin
            return COORD_MIN;
        end
        return COORD_W'(v);
    endfunction

    assign mg = S_W'(i_margin);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p[i]   = S_W'($signed(i_side.pos[i])) + S_W'(i_rc[i]);
            rad[i] = i_side.shape_kind ? S_W'(i_side.ext[0]) : S_W'(i_rad[i]);
            lo[i]  = p[i] - rad[i] - mg;
            hi[i]  = p[i] + rad[i] + mg;
            if (i_side.body_live) begin
                n_min[i] = sat(lo[i]);
                n_max[i] = sat(hi[i]);
            end else begin
                n_min[i] = COORD_MAX;
                n_max[i] = COORD_MIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_vld;
        end
        r_live <= i_side.body_live;
        r_min  <= n_min;
        r_max  <= n_max;
    end

    assign o_done      = r_done;
    assign o_box_valid = r_live;
    assign o_min       = r_min;
    assign o_max       = r_max;

endmodule

// ===== design/collider_world_bounds_top.sv =====
// World-space AABB of one collider per clock, grown by a margin register.
// Five-stage pipeline: one item accepted every cycle, result on o_done from the
// final stage; busy is never raised. Results cannot be held off, so capture every o_done.
// Depends on cwb_pkg, cwb_matrix, cwb_xform, cwb_bound.
module collider_world_bounds_top
    import cwb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic [MARGIN_W-1:0]       i_cfg_wdata,
    input  logic                      i_shape_kind,
    input  logic                      i_body_live,
    input  logic [63:0]               i_orientation,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic signed [COORD_W-1:0] i_center_z,
    input  logic [EXT_W-1:0]          i_extent_x,
    input  logic [EXT_W-1:0]          i_extent_y,
    input  logic [EXT_W-1:0]          i_extent_z,
    output logic                      o_done,
    output logic                      o_box_valid,
    output logic signed [COORD_W-1:0] o_min_x,
    output logic signed [COORD_W-1:0] o_min_y,
    output logic signed [COORD_W-1:0] o_min_z,
    output logic signed [COORD_W-1:0] o_max_x,
    output logic signed [COORD_W-1:0] o_max_y,
    output logic signed [COORD_W-1:0] o_max_z
);

    logic [MARGIN_W-1:0]     r_margin;
    t_side                   side_in;
    logic                    m_vld;
    logic signed [MAT_W-1:0] m_mat [9];
    t_side                   m_side;
    logic                    x_vld;
    logic signed [RC_W-1:0]  x_rc [3];
    logic [RAD_W-1:0]        x_rad [3];
    t_side                   x_side;
    logic signed [COORD_W-1:0] b_min [3];
    logic signed [COORD_W-1:0] b_max [3];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= '0;
        end else if (i_cfg_we) begin
            r_margin <= i_cfg_wdata;
        end
    end

    always_comb begin
        side_in.shape_kind = i_shape_kind;
        side_in.body_live  = i_body_live;
        side_in.pos        = {i_pos_z, i_pos_y, i_pos_x};
        side_in.ctr        = {i_center_z, i_center_y, i_center_x};
        side_in.ext        = {i_extent_z, i_extent_y, i_extent_x};
    end

    cwb_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_quat  (i_orientation),
        .i_side  (side_in),
        .o_vld   (m_vld),
        .o_m     (m_mat),
        .o_side  (m_side)
    );

    cwb_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (m_vld),
        .i_m     (m_mat),
        .i_side  (m_side),
        .o_vld   (x_vld),
        .o_rc    (x_rc),
        .o_rad   (x_rad),
        .o_side  (x_side)
    );

    cwb_bound u_bound (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (x_vld),
        .i_rc        (x_rc),
        .i_rad       (x_rad),
        .i_side      (x_side),
        .i_margin    (r_margin),
        .o_done      (o_done),
        .o_box_valid (o_box_valid),
        .o_min       (b_min),
        .o_max       (b_max)
    );

    assign o_min_x = b_min[0];
    assign o_min_y = b_min[1];
    assign o_min_z = b_min[2];
    assign o_max_x = b_max[0];
    assign o_max_y = b_max[1];
    assign o_max_z = b_max[2];

endmodule
